// File: src/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PAY_W  = 64;
    localparam int PRIO_W = 32;
    localparam int MODE_W = 3;
    localparam int OCC_W  = 5;

    // operation codes carried in the request
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // head fields reported for remove or peek on an empty queue
    localparam logic [PAY_W-1:0]  EMPTY_PAYLOAD = 64'hBFF0_0000_0000_0000;
    localparam logic [PRIO_W-1:0] EMPTY_PRIO    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [PAY_W-1:0]  payload;
        logic [PRIO_W-1:0] prio;
    } spq_entry_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        spq_entry_t        wdata;
        logic [IDX_W-1:0]  raddr;
    } spq_mem_req_t;

    typedef struct packed {
        logic [PAY_W-1:0]  head_payload;
        logic [PRIO_W-1:0] head_prio;
        logic              found;
        logic              dropped;
        logic              now_empty;
        logic [OCC_W-1:0]  occupancy;
    } spq_result_t;

endpackage

// File: src/spq_store.sv
module spq_store (
    input  logic                 aclk,
    input  spq_pkg::spq_mem_req_t req,
    output spq_pkg::spq_entry_t   rdata
);
    import spq_pkg::*;

    spq_entry_t mem [DEPTH];
    spq_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/spq_ctrl.sv
module spq_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [spq_pkg::MODE_W-1:0]  mode,
    input  logic [spq_pkg::PAY_W-1:0]   payload,
    input  logic [spq_pkg::PRIO_W-1:0]  prio,
    output logic                        idle,
    output logic                        done,
    input  logic                        out_free,
    output spq_pkg::spq_result_t        result,
    output spq_pkg::spq_mem_req_t       mem_req,
    input  spq_pkg::spq_entry_t         mem_rdata
);
    import spq_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN_RD  = 4'd1;
    localparam logic [3:0] ST_SCAN_CHK = 4'd2;
    localparam logic [3:0] ST_MOVE_RD  = 4'd3;
    localparam logic [3:0] ST_MOVE_WR  = 4'd4;
    localparam logic [3:0] ST_WRITE    = 4'd5;
    localparam logic [3:0] ST_PEEK_RD  = 4'd6;
    localparam logic [3:0] ST_PEEK_CHK = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [MODE_W-1:0] op_mode_reg, op_mode_next;
    spq_entry_t        op_entry_reg, op_entry_next;
    logic [PAY_W-1:0]  res_pay_reg, res_pay_next;
    logic [PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic              found_reg, found_next;
    logic              dropped_reg, dropped_next;

    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  rd_off;
    logic [CNT_W-1:0]  wr_off;
    logic              stored_greater;
    logic              full;

    // compare unit: stored priority strictly above the new one
    assign stored_greater = $signed(mem_rdata.prio) > $signed(op_entry_reg.prio);

    assign idx_inc = idx_reg + CNT_W'(1);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign full    = (count_reg == CNT_W'(DEPTH));

    // shared ring address adders
    assign rd_off = (state_reg == ST_MOVE_RD) ? idx_dec : idx_reg;
    assign wr_off = (state_reg == ST_MOVE_WR) ? idx_reg : pos_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        op_mode_next  = op_mode_reg;
        op_entry_next = op_entry_reg;
        res_pay_next  = res_pay_reg;
        res_prio_next = res_prio_reg;
        found_next    = found_reg;
        dropped_next  = dropped_reg;

        mem_req.we    = 1'b0;
        mem_req.raddr = head_reg + rd_off[IDX_W-1:0];
        mem_req.waddr = head_reg + wr_off[IDX_W-1:0];
        mem_req.wdata = (state_reg == ST_MOVE_WR) ? mem_rdata : op_entry_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    op_mode_next          = mode;
                    op_entry_next.payload = payload;
                    op_entry_next.prio    = prio;
                    res_pay_next          = '0;
                    res_prio_next         = '0;
                    found_next            = 1'b0;
                    dropped_next          = 1'b0;
                    idx_next              = '0;
                    state_next            = ST_DONE;
                    unique case (mode) inside
                        MODE_APPEND, MODE_INSERT: begin
                            if (full) begin
                                dropped_next = 1'b1;
                            end else if (mode == MODE_APPEND || count_reg == '0) begin
                                pos_next   = count_reg;
                                state_next = ST_WRITE;
                            end else begin
                                state_next = ST_SCAN_RD;
                            end
                        end
                        MODE_REMOVE, MODE_PEEK: begin
                            if (count_reg == '0) begin
                                res_pay_next  = EMPTY_PAYLOAD;
                                res_prio_next = EMPTY_PRIO;
                            end else begin
                                state_next = ST_PEEK_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (stored_greater) begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = ST_MOVE_RD;
                end else if (idx_inc == count_reg) begin
                    pos_next   = count_reg;
                    state_next = ST_WRITE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MOVE_RD: begin
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                mem_req.we = 1'b1;
                idx_next   = idx_dec;
                state_next = (idx_dec == pos_reg) ? ST_WRITE : ST_MOVE_RD;
            end
            ST_WRITE: begin
                mem_req.we = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_DONE;
            end
            ST_PEEK_RD: begin
                state_next = ST_PEEK_CHK;
            end
            ST_PEEK_CHK: begin
                res_pay_next  = mem_rdata.payload;
                res_prio_next = mem_rdata.prio;
                found_next    = 1'b1;
                if (op_mode_reg == MODE_REMOVE) begin
                    head_next  = head_reg + IDX_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        op_mode_reg  <= op_mode_next;
        op_entry_reg <= op_entry_next;
        res_pay_reg  <= res_pay_next;
        res_prio_reg <= res_prio_next;
        found_reg    <= found_next;
        dropped_reg  <= dropped_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign result.head_payload = res_pay_reg;
    assign result.head_prio    = res_prio_reg;
    assign result.found        = found_reg;
    assign result.dropped      = dropped_reg;
    assign result.now_empty    = (count_reg == '0);
    assign result.occupancy    = OCC_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_move_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOVE_RD) |-> (idx_reg > pos_reg && idx_reg <= count_reg))
        else $error("shift index outside gap window");

    a_scan_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_CHK) |-> (idx_reg < count_reg))
        else $error("scan past last entry");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> !full)
        else $error("store into full queue");

    a_found_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !(found_reg && dropped_reg))
        else $error("found and dropped together");

endmodule

// File: src/stable_priority_queue_unit.sv
// one request at a time; the scan and the gap shift run through one
//   compare and one entry store, reading and then checking or writing each visited entry
// the result register frees the input side: a new request is taken while a result waits
// reset: synchronous active-low aresetn empties the queue; entry storage is not cleared
module stable_priority_queue_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // payload[63:0], prio[95:64]
    input  logic [2:0]   s_tuser,   // mode[2:0]
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // head_payload[63:0], head_prio[95:64], found[96],
                                    // dropped[97], now_empty[98], occupancy[103:99]
);
    import spq_pkg::*;

    spq_mem_req_t mem_req;
    spq_entry_t   mem_rdata;
    spq_result_t  result;
    logic         idle;
    logic         done;
    logic         out_free;
    logic         start;

    logic         m_tvalid_reg, m_tvalid_next;
    logic [103:0] m_tdata_reg, m_tdata_next;

    // request accepted whenever the sequencer is idle
    assign s_tready = idle;
    assign start    = s_tvalid && idle;

    // result register can take a new result when empty or draining this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    spq_store u_store (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    spq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .mode      (s_tuser[MODE_W-1:0]),
        .payload   (s_tdata[PAY_W-1:0]),
        .prio      (s_tdata[PAY_W+PRIO_W-1:PAY_W]),
        .idle      (idle),
        .done      (done),
        .out_free  (out_free),
        .result    (result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // pack the result, head payload in the lowest bits
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {result.occupancy, result.now_empty, result.dropped,
                             result.found, result.head_prio, result.head_payload};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/stable_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
    import spq_pkg::*;

    // modes 5..7 carry no operation
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    localparam int RANDOM_REQS  = 1700;
    localparam int IDLE_PCT     = 35;
    localparam int CALM_LO      = 900;    // window of requests/results with no idling
    localparam int CALM_HI      = 1200;
    localparam int STALL_AT     = 500;    // result count that starts the long receiver stall
    localparam int STALL_CYCLES = 300;
    localparam int TAIL_CYCLES  = 40;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [PAY_W-1:0]  payload;
        logic [PRIO_W-1:0] prio;
        bit                wait_drain;   // hold this request until all results are back
    } pq_request_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata  = '0;   // payload[63:0], prio[95:64]
    logic [2:0]   s_tuser  = '0;   // mode[2:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;         // head_payload[63:0], head_prio[95:64], found[96],
                                   // dropped[97], now_empty[98], occupancy[103:99]

    pq_request_t  req_backlog[$];
    spq_result_t  pending_reports[$];
    int           reqs_taken    = 0;
    int           reports_seen  = 0;
    int           mismatches    = 0;
    bit           req_taken_now = 1'b0;

    // shadow copy of the queue contents
    logic [PAY_W-1:0]  shadow_payload[DEPTH];
    logic [PRIO_W-1:0] shadow_prio[DEPTH];
    int                shadow_count = 0;

    stable_priority_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // applies one request to the shadow queue and returns the report it must produce
    function automatic spq_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                  input logic [PAY_W-1:0] payload,
                                                  input logic [PRIO_W-1:0] prio);
        spq_result_t rep;
        int          pos;
        rep = '0;
        case (mode) inside
            MODE_APPEND, MODE_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    rep.dropped = 1'b1;
                end else begin
                    pos = shadow_count;
                    // stable insert: ahead of the first entry with strictly greater priority
                    if (mode == MODE_INSERT)
                        for (int i = shadow_count - 1; i >= 0; i--)
                            if ($signed(shadow_prio[i]) > $signed(prio))
                                pos = i;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_payload[i] = shadow_payload[i-1];
                        shadow_prio[i]    = shadow_prio[i-1];
                    end
                    shadow_payload[pos] = payload;
                    shadow_prio[pos]    = prio;
                    shadow_count++;
                end
            end
            MODE_REMOVE, MODE_PEEK: begin
                if (shadow_count == 0) begin
                    rep.head_payload = EMPTY_PAYLOAD;
                    rep.head_prio    = EMPTY_PRIO;
                end else begin
                    rep.head_payload = shadow_payload[0];
                    rep.head_prio    = shadow_prio[0];
                    rep.found        = 1'b1;
                    if (mode == MODE_REMOVE) begin
                        for (int i = 1; i < shadow_count; i++) begin
                            shadow_payload[i-1] = shadow_payload[i];
                            shadow_prio[i-1]    = shadow_prio[i];
                        end
                        shadow_count--;
                    end
                end
            end
            MODE_CLEAR: shadow_count = 0;
            default: ;
        endcase
        rep.now_empty = (shadow_count == 0);
        rep.occupancy = shadow_count[OCC_W-1:0];
        return rep;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_req(input logic [MODE_W-1:0] mode, input logic [PAY_W-1:0] payload,
                            input logic [PRIO_W-1:0] prio, input bit wait_drain);
        pq_request_t req;
        req.mode       = mode;
        req.payload    = payload;
        req.prio       = prio;
        req.wait_drain = wait_drain;
        req_backlog.push_back(req);
    endtask

    // rising edge: record accepted requests and check accepted results
    always @(posedge aclk) begin : watch
        spq_result_t got;
        spq_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pending_reports.push_back(apply_request(s_tuser, s_tdata[63:0], s_tdata[95:64]));
                req_taken_now = 1'b1;
                reqs_taken++;
            end
            if (m_tvalid && m_tready) begin
                got.head_payload = m_tdata[63:0];
                got.head_prio    = m_tdata[95:64];
                got.found        = m_tdata[96];
                got.dropped      = m_tdata[97];
                got.now_empty    = m_tdata[98];
                got.occupancy    = m_tdata[103:99];
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    report_field("head_payload", want.head_payload, got.head_payload);
                    report_field("head_prio", want.head_prio, got.head_prio);
                    report_field("found", want.found, got.found);
                    report_field("dropped", want.dropped, got.dropped);
                    report_field("now_empty", want.now_empty, got.now_empty);
                    report_field("occupancy", want.occupancy, got.occupancy);
                end
            end
        end
    end

    // request driver, falling edge
    always @(negedge aclk) begin : drive_req
        pq_request_t nxt;
        bit          calm;
        calm = (reqs_taken >= CALM_LO) && (reqs_taken < CALM_HI);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !req_taken_now) begin
            // request still waiting for s_tready, keep it up
        end else if (req_backlog.size() != 0
                     && !(req_backlog[0].wait_drain && pending_reports.size() != 0)
                     && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt = req_backlog.pop_front();
            s_tuser  <= nxt.mode;
            s_tdata  <= {nxt.prio, nxt.payload};
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
        req_taken_now = 1'b0;
    end

    // result receiver, falling edge; one long stall lets the block back up
    always @(negedge aclk) begin : drive_ready
        int stall_left;
        bit stall_done;
        bit calm;
        calm = (reports_seen >= CALM_LO) && (reports_seen < CALM_HI);
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            stall_done = 1'b0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!stall_done && reports_seen >= STALL_AT) begin
            m_tready <= 1'b0;
            stall_left = STALL_CYCLES - 1;
            stall_done = 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin : stimulus
        int                r;
        int                ins_hi;
        int                app_hi;
        int                rem_hi;
        logic [MODE_W-1:0] md;
        logic [PRIO_W-1:0] pr;

        // empty queue: remove and peek report the empty pattern, spare modes do nothing
        push_req(MODE_PEEK, '1, '1, 1'b0);
        push_req(MODE_REMOVE, '0, '0, 1'b0);
        push_req(MODE_SPARE_LO, {$urandom, $urandom}, $urandom, 1'b0);
        push_req(MODE_SPARE_MID, {$urandom, $urandom}, $urandom, 1'b0);
        push_req(MODE_SPARE_HI, {$urandom, $urandom}, $urandom, 1'b0);
        // priority extremes and ties while filling up
        push_req(MODE_INSERT, '1, 32'h7FFF_FFFF, 1'b0);
        push_req(MODE_INSERT, '0, 32'h8000_0000, 1'b0);
        push_req(MODE_INSERT, {$urandom, $urandom}, 32'd0, 1'b0);
        push_req(MODE_INSERT, {$urandom, $urandom}, 32'd0, 1'b0);
        push_req(MODE_INSERT, {$urandom, $urandom}, 32'hFFFF_FFFF, 1'b0);
        push_req(MODE_INSERT, {$urandom, $urandom}, 32'h7FFF_FFFF, 1'b0);
        push_req(MODE_APPEND, {$urandom, $urandom}, 32'h8000_0000, 1'b0);
        for (int k = 0; k < 9; k++)
            push_req((k % 2) ? MODE_APPEND : MODE_INSERT, {$urandom, $urandom},
                     int'($urandom_range(0, 4)) - 2, 1'b0);
        // full queue: both kinds of insert get dropped
        push_req(MODE_APPEND, {$urandom, $urandom}, 32'd0, 1'b0);
        push_req(MODE_INSERT, {$urandom, $urandom}, 32'h8000_0000, 1'b0);
        push_req(MODE_PEEK, '0, '0, 1'b0);
        push_req(MODE_REMOVE, '0, '0, 1'b0);
        push_req(MODE_CLEAR, '0, '0, 1'b0);
        push_req(MODE_PEEK, '0, '0, 1'b0);

        // random part: fill-heavy, drain-heavy and balanced phases in turn
        for (int k = 0; k < RANDOM_REQS; k++) begin
            case ((k / 150) % 3)
                0:       begin app_hi = 25; ins_hi = 70; rem_hi = 89; end
                1:       begin app_hi = 10; ins_hi = 25; rem_hi = 80; end
                default: begin app_hi = 20; ins_hi = 48; rem_hi = 83; end
            endcase
            r = $urandom_range(0, 99);
            if (r < app_hi)      md = MODE_APPEND;
            else if (r < ins_hi) md = MODE_INSERT;
            else if (r < rem_hi) md = MODE_REMOVE;
            else if (r < 95)     md = MODE_PEEK;
            else if (r < 97)     md = MODE_CLEAR;
            else if (r == 97)    md = MODE_SPARE_LO;
            else if (r == 98)    md = MODE_SPARE_MID;
            else                 md = MODE_SPARE_HI;
            // mostly a narrow priority range so ties are common
            case ($urandom_range(0, 9))
                0:       pr = $urandom;
                1:       pr = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: pr = int'($urandom_range(0, 6)) - 3;
            endcase
            push_req(md, {$urandom, $urandom}, pr, (k % 400) == 399);
        end

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk); while (req_backlog.size() != 0 || s_tvalid);
        do @(negedge aclk); while (pending_reports.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
src/spq_pkg.sv
src/spq_store.sv
src/spq_ctrl.sv
src/stable_priority_queue_unit.sv
tb/stable_priority_queue_unit_tb.sv
